// ----- hw/rtl/spa_pkg.sv -----
// Package for the slot pool allocator: field widths, operation and status
// codes, controller states and the free-list command struct.
// No dependencies; every other file of the block depends on it.
package spa_pkg;

  localparam int unsigned SLOTS_DEF = 256;  // default pool depth
  localparam int unsigned CNT_W     = 9;    // slot_count and bump counter width
  localparam int unsigned SLOT_W    = 8;    // slot index width on the ports
  localparam int unsigned STATUS_W  = 2;
  localparam logic [CNT_W-1:0] SLOT_COUNT_RST = 9'd256;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } spa_action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_FREED     = 2'd2,
    ST_IGNORED   = 2'd3
  } spa_status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_POP  = 1'b1
  } spa_state_t;

  // Request from the controller to the free list.
  typedef struct packed {
    logic push;  // link free_slot in front of the head
    logic pop;   // read the head's link into a register, then advance the head from it
  } spa_list_cmd_t;

endpackage

// ----- hw/rtl/spa_if.sv -----
// Channel interfaces of the slot pool allocator: request, response and
// configuration write, each with valid/ready. Depends on spa_pkg.

interface spa_req_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [spa_pkg::SLOT_W-1:0] free_slot;
  modport source (output valid, action, free_slot, input ready);
  modport sink   (input valid, action, free_slot, output ready);
endinterface

interface spa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [spa_pkg::STATUS_W-1:0] status;
  logic [spa_pkg::SLOT_W-1:0]   slot;
  modport source (output valid, status, slot, input ready);
  modport sink   (input valid, status, slot, output ready);
endinterface

interface spa_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [spa_pkg::CNT_W-1:0] slot_count;
  modport source (output valid, slot_count, input ready);
  modport sink   (input valid, slot_count, output ready);
endinterface

// ----- hw/rtl/spa_free_list.sv -----
// LIFO free list: head register plus a per-slot link memory with a
// registered read port. Depends on spa_pkg.
module spa_free_list #(
  parameter int unsigned SLOTS = spa_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  spa_pkg::spa_list_cmd_t        cmd,
  input  logic [spa_pkg::SLOT_W-1:0]    push_slot,
  output logic [$clog2(SLOTS+1)-1:0]    head,
  output logic                          empty
);
  import spa_pkg::*;

  localparam int unsigned LINK_W = $clog2(SLOTS + 1);
  localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [LINK_W-1:0] EMPTY_LINK = LINK_W'(SLOTS);

  logic [LINK_W-1:0] link_mem [SLOTS];
  logic [LINK_W-1:0] rd_link;
  logic              pop_pend;

  assign empty = (head == EMPTY_LINK);

  // Memory: one write or one read per cycle, read data registered.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      link_mem[IDX_W'(push_slot)] <= head;
    end
    if (cmd.pop) begin
      rd_link <= link_mem[IDX_W'(head)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= EMPTY_LINK;
      pop_pend <= 1'b0;
    end else begin
      pop_pend <= cmd.pop;
      if (pop_pend) begin
        head <= rd_link;
      end else if (cmd.push) begin
        head <= LINK_W'(push_slot);
      end
    end
  end

endmodule

// ----- hw/rtl/slot_pool_allocator_core.sv -----
// Slot pool allocator top level: request decode, bump counter, slot_count
// register and response register. Depends on spa_pkg, spa_if, spa_free_list.
//
//   channel | dir | payload              | transfer when
//   --------+-----+----------------------+---------------------------
//   req     | in  | action, free_slot    | req.valid  & req.ready
//   rsp     | out | status, slot         | rsp.valid  & rsp.ready
//   cfg     | in  | slot_count (9 bits)  | cfg.valid  & cfg.ready
//
// A free, a bump allocation or an exhausted report loads the response
// register directly; an allocation from the free list first passes S_POP,
// which waits for the registered read of the head's link in the link memory.
// Reset: control state clears at once; the link memory is not cleared
// (an entry is only read after it was pushed), so there is no clearing pass.
// Stalls: a finished response waits in the output register; a new request
// is taken in the cycle that register drains. cfg is always ready.
module slot_pool_allocator_core #(
  parameter int unsigned SLOTS = spa_pkg::SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  spa_req_if.sink   req,
  spa_rsp_if.source rsp,
  spa_cfg_if.sink   cfg
);
  import spa_pkg::*;

  localparam int unsigned LINK_W = $clog2(SLOTS + 1);

  spa_state_t        state, state_next;
  logic [CNT_W-1:0]  slot_count;
  logic [CNT_W-1:0]  bump_count, bump_next;
  logic [CNT_W-1:0]  limit;
  logic [CNT_W-1:0]  req_slot;

  // Response register
  logic              out_valid;
  spa_status_t       out_status;
  logic [SLOT_W-1:0] out_slot;

  // Produced this cycle
  logic              res_load;
  spa_status_t       res_status;
  logic [SLOT_W-1:0] res_slot;

  logic              req_fire;
  spa_list_cmd_t     list_cmd;
  logic [LINK_W-1:0] head;
  logic              list_empty;

  // Limit is slot_count clamped to the pool depth.
  assign limit    = (32'(slot_count) < SLOTS) ? slot_count : CNT_W'(SLOTS);
  assign req_slot = CNT_W'(req.free_slot);
  // Accept only in idle, when the response register is empty or drains now.
  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign req_fire = req.valid && req.ready;

  assign cfg.ready  = 1'b1;
  assign rsp.valid  = out_valid;
  assign rsp.status = out_status;
  assign rsp.slot   = out_slot;

  spa_free_list #(
    .SLOTS (SLOTS)
  ) u_free_list (
    .clk       (clk),
    .rst       (rst),
    .cmd       (list_cmd),
    .push_slot (req.free_slot),
    .head      (head),
    .empty     (list_empty)
  );

  // Next state: leave idle only for a pop, which waits for the link read.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_fire && (req.action == ACT_ALLOC) && !list_empty) begin
          state_next = S_POP;
        end
      end
      S_POP: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    list_cmd   = '0;
    bump_next  = bump_count;
    res_load   = 1'b0;
    res_status = ST_ALLOCATED;
    res_slot   = '0;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          if (req.action == ACT_ALLOC) begin
            if (!list_empty) begin
              list_cmd.pop = 1'b1;  // result follows from S_POP
            end else if (bump_count < limit) begin
              res_load   = 1'b1;
              res_status = ST_ALLOCATED;
              res_slot   = SLOT_W'(bump_count);
              bump_next  = bump_count + 1'b1;
            end else begin
              res_load   = 1'b1;
              res_status = ST_EXHAUSTED;
            end
          end else begin
            res_load = 1'b1;
            if (req_slot >= limit) begin
              res_status = ST_IGNORED;
            end else begin
              res_status = ST_FREED;
              // Returning the most recently bumped slot: lower the counter.
              if ((bump_count != '0) && (req_slot == bump_count - 1'b1)) begin
                bump_next = bump_count - 1'b1;
              end else begin
                list_cmd.push = 1'b1;
              end
            end
          end
        end
      end
      S_POP: begin
        // Head still shows the popped slot; it advances at this edge.
        res_load   = 1'b1;
        res_status = ST_ALLOCATED;
        res_slot   = SLOT_W'(head);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_count <= SLOT_COUNT_RST;
      bump_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      bump_count <= bump_next;
      if (cfg.valid && cfg.ready) begin
        slot_count <= cfg.slot_count;
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Response payload: hold until the next result is loaded.
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status <= res_status;
      out_slot   <= res_slot;
    end
  end

endmodule

// ----- hw/rtl/spa_checker.sv -----
// Port-level checks for slot_pool_allocator_core and the bind that
// attaches them. Depends on spa_pkg and the top level.
module spa_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         req_action,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [spa_pkg::STATUS_W-1:0] rsp_status,
  input logic [spa_pkg::SLOT_W-1:0]   rsp_slot
);
  import spa_pkg::*;

  // A stalled response holds its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot))
    else $error("stalled response changed");

  // Only an allocation carries a slot.
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != ST_ALLOCATED) |-> rsp_slot == '0)
    else $error("non-allocation response with nonzero slot");

  // A free is answered in the next cycle with a freed or ignored status.
  a_free_status: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_action == ACT_FREE) |=>
      rsp_valid && ((rsp_status == ST_FREED) || (rsp_status == ST_IGNORED)))
    else $error("free transfer without free response");

  // An allocation either answers next cycle or blocks requests while it pops.
  a_alloc_progress: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_action == ACT_ALLOC) |=>
      (rsp_valid && ((rsp_status == ST_ALLOCATED) || (rsp_status == ST_EXHAUSTED)))
      || !req_ready)
    else $error("allocation neither answered nor blocking");

endmodule

bind slot_pool_allocator_core spa_checker u_spa_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_action (req.action),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_slot   (rsp.slot)
);
